// ===== sv/water_column_layer_derivative_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the water column layer derivative block.
// These wrap concurrent assertions, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef WATER_COLUMN_LAYER_DERIVATIVE_DEFINES_SVH
`define WATER_COLUMN_LAYER_DERIVATIVE_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define WCLD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define WCLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/wcld_pkg.sv =====
// ----------------------------------------------------------------------------
// wcld_pkg
// Widths, register indexes and mode codes of the layer derivative block.
// ----------------------------------------------------------------------------
`default_nettype none
package wcld_pkg;
   localparam int MaxLayers = 128;
   localparam int FracBits  = 16;
   localparam int IdxW      = 8;

   localparam logic [1:0] CSR_BOTTOM_MODE    = 2'd0;
   localparam logic [1:0] CSR_BOTTOM_SINKING = 2'd1;
   localparam logic [1:0] CSR_BOTTOM_GROWTH  = 2'd2;

   localparam logic [1:0] MODE_OFF = 2'd1;

   localparam logic signed [63:0] QMax = 64'sd2147483647;
   localparam logic signed [63:0] QMin = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > QMax) return 32'sh7fffffff;
      if (v < QMin) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

// ===== sv/water_column_layer_derivative.sv =====
// ----------------------------------------------------------------------------
// water_column_layer_derivative
// Streams layers of a water column and gives each layer's rate of change.
// ----------------------------------------------------------------------------
// An inner layer holds ready low after its beat while it runs six Q16.16
// divisions on one shared restoring divider, plus set-up, multiply and result
// steps, so the block takes a new layer only once it is through with the last.
// The top layer needs three divisions; a bottom layer adds its own rate beat
// and an end-of-column beat. Result beats are held until taken; a stall holds the sequence.
// Reset is synchronous and active high; registers return to 2, 2, 2, column state to 0.
`default_nettype none
`include "water_column_layer_derivative_defines.svh"
module water_column_layer_derivative
   import wcld_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [30:0]        req_thickness,
   input  wire logic signed [31:0] req_sink_coeff,
   input  wire logic signed [31:0] req_growth_coeff,
   input  wire logic signed [31:0] req_loss_coeff,
   input  wire logic signed [31:0] req_diffusivity,
   input  wire logic signed [31:0] req_concentration,
   input  wire logic               req_is_bottom,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [IdxW-1:0]         rsp_layer_index,
   output logic signed [31:0]      rsp_rate,
   output logic                    rsp_end_of_column,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [1:0]         csr_data
);

   // The sequence of one layer. Divisions leave their quotient in q_ff.
   typedef enum logic [4:0] {
      S_IDLE, S_KD, S_CZ, S_CZP, S_FZ, S_OUT0, S_SINKD, S_SINK, S_GROW,
      S_MD1, S_MD2, S_YY, S_LOSS, S_BOT, S_OUT1, S_OUT2, S_DIV
   } state_type;

   state_type state_ff, ret_ff;

   logic [1:0] mode_ff, sinkon_ff, growon_ff;

   // Captured layer beat.
   logic [30:0]        thick_ff;
   logic signed [31:0] s_ff, r_ff, m_ff, dif_ff, y_ff;
   logic               bot_ff;

   // Column state.
   logic signed [31:0] pconc_ff, pgrow_ff, ploss_ff, psink_ff, p2sink_ff, pdiff_ff;
   logic [31:0]        pthick_ff;
   logic [IdxW-1:0]    count_ff;

   // Working values.
   logic signed [31:0] kd_ff, cz_ff, fz_ff, sink_ff, grow_ff, md_ff, yy_ff, loss_ff;
   logic signed [31:0] q_ff;

   // Serial divider: unsigned magnitude of a * 2^16 over a 32-bit divisor.
   logic [47:0] dnum_ff;
   logic [32:0] drem_ff;
   logic [31:0] dden_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff, dzero_ff, dasign_ff, dazero_ff;

   logic [IdxW-1:0]    oidx_ff;
   logic signed [31:0] orate_ff;
   logic               oend_ff, ovalid_ff;

   // Shared multiplier with floor shift and saturation.
   logic signed [31:0] mul_a, mul_b, mul_q;
   logic signed [63:0] mul_p;
   assign mul_p = mul_a * mul_b;
   assign mul_q = sat32(mul_p >>> FracBits);

   always_comb begin
      mul_a = kd_ff;
      mul_b = 32'sd0;
      case (state_ff)
         S_FZ:   begin mul_a = kd_ff;   mul_b = sat32(64'(cz_ff) - 64'(q_ff)); end
         S_SINK: begin mul_a = q_ff;    mul_b = y_ff; end
         S_GROW: begin mul_a = r_ff;    mul_b = y_ff; end
         S_YY:   begin mul_a = y_ff;    mul_b = y_ff; end
         S_LOSS: begin mul_a = md_ff;   mul_b = yy_ff; end
         default: begin mul_a = kd_ff;  mul_b = 32'sd0; end
      endcase
   end

   logic [32:0] dtrial;
   assign dtrial = {drem_ff[31:0], dnum_ff[47]} - {1'b0, dden_ff};

   logic signed [63:0] acc0, accb;
   assign acc0 = -64'(pdiff_ff) + 64'(fz_ff) - 64'(psink_ff) + 64'(p2sink_ff)
                 + 64'(pgrow_ff) - 64'(ploss_ff);
   assign accb = -64'(fz_ff) - 64'(sink_ff) + 64'(psink_ff) + 64'(grow_ff)
                 - 64'(loss_ff);

   logic is_bot;
   assign is_bot = bot_ff || (count_ff >= IdxW'(MaxLayers - 1));

   // A result state loads the output register when it is empty or being taken.
   logic out_load;
   assign out_load = ((state_ff == S_OUT0) || (state_ff == S_OUT1) || (state_ff == S_OUT2))
                     && (!ovalid_ff || rsp_ready);

   // The output register parts the two sides, so a waiting result does not
   // hold off the next layer.
   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = ovalid_ff;
   assign rsp_layer_index   = oidx_ff;
   assign rsp_rate          = orate_ff;
   assign rsp_end_of_column = oend_ff;

   logic [63:0] qmag;
   assign qmag = {16'd0, dnum_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         mode_ff   <= 2'd2;
         sinkon_ff <= 2'd2;
         growon_ff <= 2'd2;
         ovalid_ff <= 1'b0;
         count_ff  <= '0;
         pconc_ff  <= '0; pthick_ff <= '0; pgrow_ff <= '0; ploss_ff <= '0;
         psink_ff  <= '0; p2sink_ff <= '0; pdiff_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BOTTOM_MODE:    mode_ff   <= csr_data;
               CSR_BOTTOM_SINKING: sinkon_ff <= csr_data;
               CSR_BOTTOM_GROWTH:  growon_ff <= csr_data;
               default: ;
            endcase
         end
         if (ovalid_ff && rsp_ready && !out_load) ovalid_ff <= 1'b0;

         // Layer sequence; start_div begins a division of a by d, resuming at nxt when done.
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  thick_ff <= req_thickness; s_ff <= req_sink_coeff;
                  r_ff <= req_growth_coeff; m_ff <= req_loss_coeff;
                  dif_ff <= req_diffusivity; y_ff <= req_concentration;
                  bot_ff <= req_is_bottom;
                  fz_ff  <= '0;
                  state_ff <= (count_ff != '0) ? S_KD : S_SINKD;
               end
            end
            S_KD: begin
               start_div(dif_ff, pthick_ff + {1'b0, thick_ff}, S_CZ);
            end
            S_CZ: begin
               kd_ff <= q_ff;
               start_div(y_ff, {1'b0, thick_ff}, S_CZP);
            end
            S_CZP: begin
               cz_ff <= q_ff;
               start_div(pconc_ff, pthick_ff, S_FZ);
            end
            S_FZ: begin
               fz_ff <= mul_q;
               state_ff <= S_OUT0;
            end
            S_OUT0: begin
               if (out_load) begin
                  ovalid_ff <= 1'b1;
                  oidx_ff   <= count_ff - 1'b1;
                  orate_ff  <= sat32(acc0);
                  oend_ff   <= 1'b0;
                  state_ff  <= S_SINKD;
               end
            end
            S_SINKD: start_div(s_ff, {1'b0, thick_ff}, S_SINK);
            S_SINK: begin
               sink_ff  <= (is_bot && sinkon_ff == MODE_OFF) ? 32'sd0 : mul_q;
               state_ff <= S_GROW;
            end
            S_GROW: begin
               grow_ff  <= (is_bot && growon_ff == MODE_OFF) ? 32'sd0 : mul_q;
               start_div(m_ff, {1'b0, thick_ff}, S_MD1);
            end
            S_MD1: start_div(q_ff, {1'b0, thick_ff}, S_MD2);
            S_MD2: begin
               md_ff    <= q_ff;
               state_ff <= S_YY;
            end
            S_YY: begin
               yy_ff    <= mul_q;
               state_ff <= S_LOSS;
            end
            S_LOSS: begin
               loss_ff  <= mul_q;
               state_ff <= S_BOT;
            end
            S_BOT: begin
               if (is_bot) begin
                  state_ff <= S_OUT1;
               end else begin
                  p2sink_ff <= psink_ff; psink_ff <= sink_ff;
                  pgrow_ff  <= grow_ff;  ploss_ff <= loss_ff;
                  pdiff_ff  <= fz_ff;    pconc_ff <= y_ff;
                  pthick_ff <= {1'b0, thick_ff};
                  count_ff  <= count_ff + 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            S_OUT1: begin
               if (out_load) begin
                  ovalid_ff <= 1'b1;
                  oidx_ff   <= count_ff;
                  orate_ff  <= (mode_ff == MODE_OFF) ? 32'sd0 : sat32(accb);
                  oend_ff   <= 1'b0;
                  state_ff  <= S_OUT2;
               end
            end
            S_OUT2: begin
               if (out_load) begin
                  ovalid_ff <= 1'b1;
                  oidx_ff   <= count_ff + 1'b1;
                  orate_ff  <= '0;
                  oend_ff   <= 1'b1;
                  count_ff  <= '0;
                  pconc_ff  <= '0; pthick_ff <= '0; pgrow_ff <= '0; ploss_ff <= '0;
                  psink_ff  <= '0; p2sink_ff <= '0; pdiff_ff <= '0;
                  state_ff  <= S_IDLE;
               end
            end
            S_DIV: begin
               if (dcnt_ff != '0) begin
                  dcnt_ff <= dcnt_ff - 1'b1;
                  dnum_ff <= {dnum_ff[46:0], ~dtrial[32]};
                  drem_ff <= dtrial[32] ? {drem_ff[31:0], dnum_ff[47]} : dtrial;
               end else begin
                  if (dzero_ff)
                     q_ff <= dazero_ff ? 32'sd0 : (dasign_ff ? 32'sh80000000 : 32'sh7fffffff);
                  else
                     q_ff <= sat32(dneg_ff ? -$signed(qmag) : $signed(qmag));
                  state_ff <= ret_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Loads the serial divider with |a| * 2^16 over d.
   task automatic start_div(input logic signed [31:0] a, input logic [31:0] d,
                            input state_type nxt);
      logic [31:0] mag;
      mag = a[31] ? 32'(-a) : 32'(a);
      dnum_ff   <= {mag, 16'd0};
      drem_ff   <= '0;
      dden_ff   <= d;
      dcnt_ff   <= 6'd48;
      dneg_ff   <= a[31];
      dzero_ff  <= (d == '0);
      dasign_ff <= a[31];
      dazero_ff <= (a == '0);
      ret_ff    <= nxt;
      state_ff  <= S_DIV;
   endtask

   `WCLD_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE,
      "ready outside idle")
   `WCLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_rate), "result beat dropped")
   `WCLD_ASSERT_IMP(a_end_zero, clock, reset, rsp_valid && rsp_end_of_column,
      rsp_rate == 32'sd0, "end beat carries a rate")

endmodule
`default_nettype wire

// ===== test/water_column_layer_derivative_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// water_column_layer_derivative_tb
// Streams water columns of random and edge-case layers through the block,
// predicts every rate beat in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module water_column_layer_derivative_tb;
   import wcld_pkg::*;

   localparam int StallLimit = 20000;  // cycles without any beat before giving up
   localparam int SettleCycles = 600;  // idle cycles that let the block settle before the modes change

   typedef struct packed {
      logic [30:0]        thickness;
      logic signed [31:0] sink_coeff;
      logic signed [31:0] growth_coeff;
      logic signed [31:0] loss_coeff;
      logic signed [31:0] diffusivity;
      logic signed [31:0] concentration;
      logic               is_bottom;
   } layer_type;

   typedef struct packed {
      logic [IdxW-1:0]    layer_index;
      logic signed [31:0] rate;
      logic               end_of_column;
   } rate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [30:0] req_thickness = '0;
   logic signed [31:0] req_sink_coeff = '0;
   logic signed [31:0] req_growth_coeff = '0;
   logic signed [31:0] req_loss_coeff = '0;
   logic signed [31:0] req_diffusivity = '0;
   logic signed [31:0] req_concentration = '0;
   logic req_is_bottom = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [IdxW-1:0] rsp_layer_index;
   logic signed [31:0] rsp_rate;
   logic rsp_end_of_column;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [1:0] csr_data = '0;

   water_column_layer_derivative dut (
      .clock, .reset, .req_valid, .req_ready, .req_thickness, .req_sink_coeff,
      .req_growth_coeff, .req_loss_coeff, .req_diffusivity, .req_concentration,
      .req_is_bottom, .rsp_valid, .rsp_ready, .rsp_layer_index, .rsp_rate,
      .rsp_end_of_column, .csr_write, .csr_index, .csr_data
   );

   always #2 clock = ~clock;

   // Layers waiting to be driven, and rate beats the block still owes us.
   layer_type layer_q[$];
   rate_type  rate_q[$];
   layer_type cur_layer;
   int     mismatches = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;

   // Our own copy of the bottom modes and of the running column.
   logic [1:0] mode_bottom = 2'd2;
   logic [1:0] mode_sinking = 2'd2;
   logic [1:0] mode_growth = 2'd2;
   longint col_conc, col_thick, col_growth, col_loss, col_sink, col_sink_above, col_diff;
   int     col_count;

   function automatic longint clamp32(longint v);
      if (v > QMax) return QMax;
      if (v < QMin) return QMin;
      return v;
   endfunction

   // Products are floored, so an arithmetic shift is exactly right here.
   function automatic longint qmul(longint a, longint b);
      return clamp32((a * b) >>> FracBits);
   endfunction

   // Quotients truncate toward zero; division by zero saturates to the sign.
   function automatic longint qdiv(longint a, longint d);
      if (d == 0) begin
         if (a > 0) return QMax;
         if (a < 0) return QMin;
         return 0;
      end
      return clamp32((a * (64'sd1 <<< FracBits)) / d);
   endfunction

   function automatic void clear_column();
      col_conc = 0; col_thick = 0; col_growth = 0; col_loss = 0;
      col_sink = 0; col_sink_above = 0; col_diff = 0; col_count = 0;
   endfunction

   // Works out the rate beats that one accepted layer releases.
   function automatic void predict_layer_rates(layer_type l);
      longint thick, y, fz, sink, grow, loss, above, kd, cz, czp, acc;
      bit     bottom;
      thick = l.thickness;
      y = l.concentration;
      fz = 0;
      above = 0;
      bottom = l.is_bottom || (col_count >= MaxLayers - 1);
      if (col_count > 0) begin
         kd = qdiv(l.diffusivity, col_thick + thick);
         cz = qdiv(y, thick);
         czp = qdiv(col_conc, col_thick);
         fz = qmul(kd, clamp32(cz - czp));
         acc = -col_diff + fz - col_sink + col_sink_above + col_growth - col_loss;
         rate_q.push_back('{IdxW'(col_count - 1), 32'(clamp32(acc)), 1'b0});
         above = col_sink;
      end
      sink = (bottom && mode_sinking == MODE_OFF) ? 0 : qmul(qdiv(l.sink_coeff, thick), y);
      grow = (bottom && mode_growth == MODE_OFF) ? 0 : qmul(l.growth_coeff, y);
      loss = qmul(qdiv(qdiv(l.loss_coeff, thick), thick), qmul(y, y));
      if (bottom) begin
         acc = (mode_bottom == MODE_OFF) ? 0 : clamp32(-fz - sink + above + grow - loss);
         rate_q.push_back('{IdxW'(col_count), 32'(acc), 1'b0});
         rate_q.push_back('{IdxW'(col_count + 1), 32'sd0, 1'b1});
         clear_column();
      end else begin
         col_sink_above = col_sink;
         col_sink = sink;
         col_growth = grow;
         col_loss = loss;
         col_diff = fz;
         col_conc = y;
         col_thick = thick;
         col_count++;
      end
   endfunction

   // Driver: presents the next pending layer once the previous beat has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_layer_rates(cur_layer);
         if (!req_valid || req_ready) begin
            if (layer_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_layer = layer_q.pop_front();
               req_thickness <= cur_layer.thickness;
               req_sink_coeff <= cur_layer.sink_coeff;
               req_growth_coeff <= cur_layer.growth_coeff;
               req_loss_coeff <= cur_layer.loss_coeff;
               req_diffusivity <= cur_layer.diffusivity;
               req_concentration <= cur_layer.concentration;
               req_is_bottom <= cur_layer.is_bottom;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Monitor: stalls the result side at random and checks each beat taken.
   always @(posedge clock) begin
      rate_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rate_q.size() == 0) begin
               report_mismatch("unexpected beat, layer_index", rsp_layer_index, -1);
            end else begin
               want = rate_q.pop_front();
               if (rsp_layer_index !== want.layer_index)
                  report_mismatch("layer_index", rsp_layer_index, want.layer_index);
               if (rsp_rate !== want.rate)
                  report_mismatch("rate", rsp_rate, want.rate);
               if (rsp_end_of_column !== want.end_of_column)
                  report_mismatch("end_of_column", rsp_end_of_column, want.end_of_column);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: a long spell with no beat on either side means the block hung.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Field values lean on the saturation points and on values near one.
   function automatic logic signed [31:0] pick_q();
      case ($urandom_range(6))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sd0;
         3: return $signed($urandom_range(1 << 19)) - (1 << 18);
         4: return $signed($urandom_range(1 << 22)) - (1 << 21);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_thickness();
      case ($urandom_range(5))
         0: return 31'd1;
         1: return 31'h7fffffff;
         2: return 31'($urandom_range(31'h7fffffff, 1));
         default: return 31'($urandom_range(1 << 19, 1 << 12));
      endcase
   endfunction

   function automatic layer_type random_layer(bit bottom);
      return '{pick_thickness(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), bottom};
   endfunction

   task automatic queue_column(int depth);
      for (int i = 0; i < depth; i++) layer_q.push_back(random_layer(i == depth - 1));
   endtask

   // Waits until every layer has gone in and every rate beat has come out,
   // then lets the block settle before the modes may change.
   task automatic wait_for_idle();
      while (layer_q.size() != 0 || req_valid || rate_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] idx, logic [1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_BOTTOM_MODE) mode_bottom = value;
      else if (idx == CSR_BOTTOM_SINKING) mode_sinking = value;
      else mode_growth = value;
   endtask

   int sent;
   int depth;
   logic [1:0] mode_plan[5][3] = '{
      '{2'd1, 2'd1, 2'd1}, '{2'd3, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd2},
      '{2'd3, 2'd1, 2'd1}, '{2'd2, 2'd2, 2'd2}};
   int send_plan[5] = '{0, 60, 0, 34, 0};
   int recv_plan[5] = '{0, 0, 60, 34, 0};

   initial begin
      clear_column();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed columns under the reset modes: a lone bottom layer, then
      // columns built from the extremes of every field.
      layer_q.push_back('{31'h10000, 32'sh10000, 32'sh8000, 32'sh100, 32'sd0, 32'sh20000, 1'b1});
      layer_q.push_back('{31'd1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 1'b0});
      layer_q.push_back('{31'h7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 32'sh80000000, 1'b1});
      layer_q.push_back('{31'h7fffffff, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0});
      layer_q.push_back('{31'd1, 32'sh80000000, 32'sh7fffffff, 32'sd0,
                          32'sh7fffffff, 32'sh80000000, 1'b0});
      layer_q.push_back('{31'h20000, 32'sh8000, 32'sh4000, 32'sh1000,
                          32'sh30000, 32'sh18000, 1'b1});
      queue_column(4);
      queue_column(3);
      wait_for_idle();

      // Random phases: each sets new bottom modes and a new idling pattern.
      for (int p = 0; p < 5; p++) begin
         write_mode(CSR_BOTTOM_MODE, mode_plan[p][0]);
         write_mode(CSR_BOTTOM_SINKING, mode_plan[p][1]);
         write_mode(CSR_BOTTOM_GROWTH, mode_plan[p][2]);
         send_idle_pct = send_plan[p];
         recv_stall_pct = recv_plan[p];
         @(negedge clock);
         sent = 0;
         // A column longer than the block allows: the last permitted layer
         // is closed as a bottom, and the overflow starts a fresh column.
         if (p == 2) begin
            queue_column(130);
            sent = 130;
         end
         while (sent < 65) begin
            depth = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            queue_column(depth);
            sent += depth;
         end
         wait_for_idle();
      end

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== water_column_layer_derivative.f =====
+incdir+sv
sv/wcld_pkg.sv
sv/water_column_layer_derivative.sv
test/water_column_layer_derivative_tb.sv
